FILE: rtl/core/gps_pkg.sv
// Shared types, codes and constant tables for the gamepad poll sequencer.
// Used by gps_decide and gamepad_poll_sequencer; depends on nothing else.
package gps_pkg;

	// Default length of a read frame in bytes.
	localparam int FRAME_BYTES_DEF = 9;

	// Command codes of a request.
	localparam logic CMD_POLL = 1'b0;
	localparam logic CMD_BYTE = 1'b1;

	// Configuration register indexes.
	localparam logic REG_REINIT_THRESHOLD = 1'b0;
	localparam logic REG_MODE_LOCK        = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [3:0] REINIT_THRESHOLD_RST = 4'd3;
	localparam logic [7:0] MODE_LOCK_RST        = 8'h03;

	// Result status codes.
	localparam logic [2:0] ST_BUSY        = 3'd0;
	localparam logic [2:0] ST_POLL_OK     = 3'd1;
	localparam logic [2:0] ST_BAD_HEADER  = 3'd2;
	localparam logic [2:0] ST_DIGITAL     = 3'd3;
	localparam logic [2:0] ST_OTHER_MODE  = 3'd4;
	localparam logic [2:0] ST_CONFIG_DONE = 3'd5;
	localparam logic [2:0] ST_IGNORED     = 3'd6;

	// Bytes of the link protocol.
	localparam logic [7:0] HEADER_OK        = 8'h5A;
	localparam logic [7:0] MODE_DIGITAL     = 8'h41;
	localparam logic [7:0] MODE_ANALOG_RED  = 8'h73;
	localparam logic [7:0] MODE_ANALOG_PRES = 8'h79;
	localparam logic [7:0] CMD_START        = 8'h01;
	localparam logic [7:0] CMD_READ         = 8'h42;
	localparam logic [3:0] COUNT_MAX        = 4'd15;

	// Index of the last of the configuration commands in one initialization.
	localparam logic [1:0] LAST_INIT_STEP = 2'd2;
	// Position of the mode lock byte within the set-mode command.
	localparam logic [3:0] MODE_LOCK_POS  = 4'd4;
	// Number of stored frame bytes (buttons and four sticks).
	localparam int         FB_DEPTH       = 6;

	typedef struct packed {
		logic       command;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  tx_byte;
		logic        select_active;
		logic        frame_end;
		logic [2:0]  status;
		logic [15:0] buttons;
		logic [7:0]  right_x;
		logic [7:0]  right_y;
		logic [7:0]  left_x;
		logic [7:0]  left_y;
		logic        analog_mode;
	} out_item_t;

	// Control state of the sequencer, apart from the byte position.
	typedef struct packed {
		logic       open;
		logic [1:0] init_step;
		logic       init_pending;
		logic [7:0] mode_seen;
		logic [3:0] invalid_count;
		logic       analog;
	} ctl_state_t;

	// Length in bytes of a configuration command.
	function automatic logic [3:0] cfg_len(input logic [1:0] step);
		logic [3:0] len;
		len = (step == 2'd0) ? 4'd5 : 4'd9;
		return len;
	endfunction

	// Fixed bytes of the three configuration commands: enter config, set mode,
	// exit config. The position must be below nine.
	function automatic logic [7:0] cfg_byte(input logic [1:0] step, input logic [3:0] idx);
		logic [7:0] b;
		b = 8'h00;
		case (step)
			2'd0, 2'd1: begin
				if (idx == 4'd0) b = 8'h01;
				else if (idx == 4'd1) b = (step == 2'd0) ? 8'h43 : 8'h44;
				else if (idx == 4'd3) b = 8'h01;
			end
			2'd2: begin
				if (idx == 4'd0) b = 8'h01;
				else if (idx == 4'd1) b = 8'h43;
				else if (idx >= 4'd4) b = 8'h5A;
			end
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

FILE: rtl/core/gamepad_poll_sequencer.sv
// Top level of the gamepad poll sequencer: request and result registers,
// sequencer state and configuration registers. Depends on gps_pkg and gps_decide.
//
// The sequencer takes one request per clock cycle and gives exactly one result
// for each. A request is either a poll, which opens a transaction and yields the
// first byte to send, or the report of an exchanged byte, which yields the next
// byte to send or closes the transaction with a status. A request is captured
// in an input register and, once the result register is free or being emptied,
// the decision logic reads it together with the sequencer state and writes both
// the new state and the result register. Because the state is updated in that
// same cycle, requests may follow one another on every clock with no gap, and the
// sustained rate is one request per cycle for as long as results are taken.
// The result register and the input register form two slots, so a new request
// is still taken while a finished result waits for its consumer. After reset the
// sequencer runs the three configuration commands (enter config, set mode, exit
// config) as its first three transactions, and repeats them whenever the count
// of digital-mode replies in a row reaches the re-initialization threshold.
// Configuration registers are written through cfg_we, cfg_index and cfg_data:
// index 0 is the threshold (low four bits of the data), index 1 the mode lock
// byte of the set-mode command. They should be written only while the block is
// idle.
module gamepad_poll_sequencer #(
	parameter int FRAME_BYTES = gps_pkg::FRAME_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  gps_pkg::in_item_t   req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output gps_pkg::out_item_t  rsp,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [7:0]          cfg_data
);

	localparam int POS_W = $clog2(FRAME_BYTES);

	// Input register.
	logic                                valid_s1;
	gps_pkg::in_item_t                   item_s1;

	// Result register.
	logic                                rsp_valid_q;
	gps_pkg::out_item_t                  rsp_q;

	// Sequencer state.
	gps_pkg::ctl_state_t                 st_q;
	logic [POS_W-1:0]                    pos_q;
	logic [gps_pkg::FB_DEPTH-1:0][7:0]   fb_q;

	// Configuration registers.
	logic [3:0]                          reinit_threshold_q;
	logic [7:0]                          mode_lock_q;

	// Decision outputs.
	gps_pkg::ctl_state_t                 st_n;
	logic [POS_W-1:0]                    pos_n;
	logic                                fb_we;
	logic [2:0]                          fb_idx;
	gps_pkg::out_item_t                  res;

	logic                                advance;
	logic                                accept;

	// The captured request moves on whenever the result register is free or
	// being emptied in this cycle.
	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;
	assign accept    = req_valid && !req_stall;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	gps_decide #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_decide (
		.item              (item_s1),
		.st                (st_q),
		.pos               (pos_q),
		.fb                (fb_q),
		.reinit_threshold  (reinit_threshold_q),
		.mode_lock_setting (mode_lock_q),
		.st_n              (st_n),
		.pos_n             (pos_n),
		.fb_we             (fb_we),
		.fb_idx            (fb_idx),
		.res               (res)
	);

	// Handshake and sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			st_q        <= '{open: 1'b0, init_step: 2'd0, init_pending: 1'b1,
				mode_seen: 8'h00, invalid_count: 4'd0, analog: 1'b0};
			pos_q       <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end

			if (advance) begin
				rsp_valid_q <= 1'b1;
				st_q        <= st_n;
				pos_q       <= pos_n;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers need no reset. Each stored frame byte is written earlier in
	// the frame before it is reported, or is taken straight from the closing exchange.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= req;
		end
		if (advance) begin
			rsp_q <= res;
			if (fb_we) begin
				fb_q[fb_idx] <= item_s1.rx_byte;
			end
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reinit_threshold_q <= gps_pkg::REINIT_THRESHOLD_RST;
			mode_lock_q        <= gps_pkg::MODE_LOCK_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gps_pkg::REG_REINIT_THRESHOLD: reinit_threshold_q <= cfg_data[3:0];
				gps_pkg::REG_MODE_LOCK:        mode_lock_q        <= cfg_data;
			endcase
		end
	end

endmodule

FILE: rtl/core/gps_decide.sv
// Per-byte decision logic of the gamepad poll sequencer: next state and result.
// Purely combinational; depends on gps_pkg.
module gps_decide #(
	parameter int FRAME_BYTES = gps_pkg::FRAME_BYTES_DEF,
	localparam int POS_W = $clog2(FRAME_BYTES)
) (
	input  gps_pkg::in_item_t                         item,
	input  gps_pkg::ctl_state_t                       st,
	input  logic [POS_W-1:0]                          pos,
	input  logic [gps_pkg::FB_DEPTH-1:0][7:0]         fb,
	input  logic [3:0]                                reinit_threshold,
	input  logic [7:0]                                mode_lock_setting,
	output gps_pkg::ctl_state_t                       st_n,
	output logic [POS_W-1:0]                          pos_n,
	output logic                                      fb_we,
	output logic [2:0]                                fb_idx,
	output gps_pkg::out_item_t                        res
);

	localparam logic [POS_W:0] FRAME_N = (POS_W + 1)'(FRAME_BYTES);

	logic [1:0]                          cur_step;
	logic [POS_W:0]                      pos_inc;
	logic [POS_W-1:0]                    due_pos;
	logic [7:0]                          due_byte;
	logic [3:0]                          count_inc;
	logic                                closing;
	logic [gps_pkg::FB_DEPTH-1:0][7:0]   fb_view;
	logic [POS_W-1:0]                    fb_off;
	logic                                fb_in_range;

	assign cur_step  = (st.init_step > gps_pkg::LAST_INIT_STEP) ? 2'd0 : st.init_step;
	assign pos_inc   = {1'b0, pos} + (POS_W + 1)'(1);
	assign count_inc = (st.invalid_count < gps_pkg::COUNT_MAX) ?
		st.invalid_count + 4'd1 : st.invalid_count;
	assign fb_off    = pos - POS_W'(3);
	assign fb_in_range = (pos >= POS_W'(3)) && (pos <= POS_W'(8));

	// Position whose byte is sent next.
	always_comb begin
		if (item.command == gps_pkg::CMD_POLL) begin
			due_pos = st.open ? pos : '0;
		end else begin
			due_pos = pos_inc[POS_W-1:0];
		end
	end

	always_comb begin
		due_byte = 8'h00;
		if (st.init_pending) begin
			if (due_pos < POS_W'(9)) begin
				if (cur_step == 2'd1 && due_pos[3:0] == gps_pkg::MODE_LOCK_POS) begin
					due_byte = mode_lock_setting;
				end else begin
					due_byte = gps_pkg::cfg_byte(cur_step, due_pos[3:0]);
				end
			end
		end else if (due_pos == '0) begin
			due_byte = gps_pkg::CMD_START;
		end else if (due_pos == POS_W'(1)) begin
			due_byte = gps_pkg::CMD_READ;
		end
	end

	// The last stored byte may arrive in the closing exchange itself.
	always_comb begin
		for (int k = 0; k < gps_pkg::FB_DEPTH; k++) begin
			fb_view[k] = (fb_in_range && fb_off[2:0] == 3'(k)) ? item.rx_byte : fb[k];
		end
	end

	always_comb begin
		st_n    = st;
		pos_n   = pos;
		fb_we   = 1'b0;
		fb_idx  = fb_off[2:0];
		closing = 1'b0;
		res     = '0;

		if (item.command == gps_pkg::CMD_POLL) begin
			if (st.open) begin
				res.status = gps_pkg::ST_IGNORED;
			end else begin
				st_n.open = 1'b1;
				pos_n     = '0;
			end
			res.tx_byte       = due_byte;
			res.select_active = 1'b1;
		end else if (!st.open) begin
			res.status = gps_pkg::ST_IGNORED;
		end else if (st.init_pending) begin
			if (pos_inc >= (POS_W + 1)'(gps_pkg::cfg_len(cur_step))) begin
				st_n.open     = 1'b0;
				pos_n         = '0;
				res.frame_end = 1'b1;
				res.status    = gps_pkg::ST_CONFIG_DONE;
				if (cur_step >= gps_pkg::LAST_INIT_STEP) begin
					st_n.init_pending  = 1'b0;
					st_n.init_step     = 2'd0;
					st_n.invalid_count = 4'd0;
					st_n.analog        = 1'b0;
				end else begin
					st_n.init_step = cur_step + 2'd1;
				end
			end else begin
				pos_n             = pos_inc[POS_W-1:0];
				res.tx_byte       = due_byte;
				res.select_active = 1'b1;
			end
		end else begin
			if (pos == POS_W'(1)) begin
				st_n.mode_seen = item.rx_byte;
			end else if (pos == POS_W'(2)) begin
				if (item.rx_byte != gps_pkg::HEADER_OK) begin
					st_n.analog = 1'b0;
					res.status  = gps_pkg::ST_BAD_HEADER;
					closing     = 1'b1;
				end else if (st.mode_seen != gps_pkg::MODE_ANALOG_RED &&
						st.mode_seen != gps_pkg::MODE_ANALOG_PRES) begin
					st_n.analog = 1'b0;
					closing     = 1'b1;
					if (st.mode_seen == gps_pkg::MODE_DIGITAL) begin
						res.status         = gps_pkg::ST_DIGITAL;
						st_n.invalid_count = count_inc;
						if (count_inc >= reinit_threshold) begin
							st_n.init_pending = 1'b1;
							st_n.init_step    = 2'd0;
						end
					end else begin
						res.status         = gps_pkg::ST_OTHER_MODE;
						st_n.invalid_count = 4'd0;
					end
				end else begin
					st_n.analog        = 1'b1;
					st_n.invalid_count = 4'd0;
				end
			end else if (pos >= POS_W'(3)) begin
				fb_we = (pos <= POS_W'(8));
				if (pos_inc >= FRAME_N) begin
					closing     = 1'b1;
					res.status  = gps_pkg::ST_POLL_OK;
					res.buttons = {fb_view[0], fb_view[1]};
					res.right_x = fb_view[2];
					res.right_y = fb_view[3];
					res.left_x  = fb_view[4];
					res.left_y  = fb_view[5];
				end
			end

			if (closing) begin
				st_n.open     = 1'b0;
				pos_n         = '0;
				res.frame_end = 1'b1;
			end else begin
				pos_n             = pos_inc[POS_W-1:0];
				res.tx_byte       = due_byte;
				res.select_active = 1'b1;
			end
		end

		res.analog_mode = st_n.analog;
	end

endmodule
